FILE: hdl/rtwm_pkg.sv
// ----------------------------------------------------------------------------
// rtwm_pkg
// types and constants shared by the reservation table and its checker
// ----------------------------------------------------------------------------
package rtwm_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned AmountW  = 16;
  localparam int unsigned PosW     = 9;
  localparam int unsigned CountW   = 20;
  localparam int unsigned SlotIdxW = 6;

  // a pushed position with every bit set matches any stored position
  localparam logic [PosW-1:0]   PosAny   = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  // kind codes
  localparam logic KindPush  = 1'b0;
  localparam logic KindClear = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    item;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
  } entry_t;

endpackage

FILE: hdl/rtwm_ram.sv
// ----------------------------------------------------------------------------
// rtwm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rtwm_ram #(
  parameter int unsigned Width = 45,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/reserve_table_wildcard_merge.sv
// ----------------------------------------------------------------------------
// reserve_table_wildcard_merge
// reservation table with id match, wildcard position merge and
// lowest-free-slot insertion, slot state held in one ram
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | kind, item_id, amount, position
//  out     | output    | out_valid_o/out_ready_i | accepted, merged, slot_index, any_reserved
//
//  a push walks the occupied slots through the ram read port, a read state and
//  a compare state per slot (address, then compare), then the merge write or the
//  insert step; clear and id-zero pushes go straight to the finishing step
//  one transaction is in flight at a time; the result sits in an output
//  register, so the next input transaction is taken while it waits
//  reset empties the table at once through the fill count, no clearing pass
//  a stalled output only holds the finishing step, the table is already updated
//
module reserve_table_wildcard_merge #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [rtwm_pkg::IdW-1:0]       item_id_i,
  input  logic [rtwm_pkg::AmountW-1:0]   amount_i,
  input  logic signed [rtwm_pkg::PosW-1:0] position_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           accepted_o,
  output logic                           merged_o,
  output logic [rtwm_pkg::SlotIdxW-1:0]  slot_index_o,
  output logic                           any_reserved_o
);

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(ENTRIES + 1);
  localparam int unsigned EntW  = $bits(rtwm_pkg::entry_t);
  localparam logic [FillW-1:0] FillFull = FillW'(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CMP   = 6'b000100,
    S_INS   = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // slots 0 .. fill-1 are occupied: inserts always take the lowest free
  // slot and only a clear ever frees one, so the table fills in order
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;

  // captured transaction
  logic                          kind_q;
  logic [rtwm_pkg::IdW-1:0]      id_q;
  logic [rtwm_pkg::AmountW-1:0]  amount_q;
  logic [rtwm_pkg::PosW-1:0]     pos_q;

  // result being built
  logic            res_acc_q, res_acc_d;
  logic            res_mrg_q, res_mrg_d;
  logic [IdxW-1:0] res_idx_q, res_idx_d;

  // merge write-back
  logic [rtwm_pkg::CountW-1:0] sum_q, sum_d;
  rtwm_pkg::entry_t            hit_q, hit_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          out_acc_q, out_mrg_q, out_any_q;
  logic [rtwm_pkg::SlotIdxW-1:0] out_idx_q;
  logic                          out_load;

  // ram ports
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  rtwm_pkg::entry_t ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [EntW-1:0]  ram_rdata;
  rtwm_pkg::entry_t rd_entry;

  logic                        in_fire;
  logic                        slot_hit;
  logic                        last_slot;
  logic [rtwm_pkg::CountW:0]   sum_wide;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_entry   = rtwm_pkg::entry_t'(ram_rdata);

  // wildcard on the pushed side only; a stored all-ones position is ordinary
  assign slot_hit  = (rd_entry.item == id_q) &&
                     ((pos_q == rtwm_pkg::PosAny) || (rd_entry.position == pos_q));
  assign last_slot = ((FillW'(ptr_q) + FillW'(1)) == fill_q);
  assign sum_wide  = {1'b0, rd_entry.count} + (rtwm_pkg::CountW + 1)'(amount_q);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ptr_d     = ptr_q;
    res_acc_d = res_acc_q;
    res_mrg_d = res_mrg_q;
    res_idx_d = res_idx_q;
    sum_d     = sum_q;
    hit_d     = hit_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = hit_q;
    ram_raddr = ptr_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_acc_d = 1'b0;
          res_mrg_d = 1'b0;
          res_idx_d = '0;
          ptr_d     = '0;
          if (kind_i == rtwm_pkg::KindClear) begin
            fill_d  = '0;
            state_d = S_DONE;
          end else if (item_id_i == '0) begin
            state_d = S_DONE;
          end else if (fill_q == '0) begin
            state_d = S_INS;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (slot_hit) begin
          sum_d   = sum_wide[rtwm_pkg::CountW] ? rtwm_pkg::CountMax
                                               : sum_wide[rtwm_pkg::CountW-1:0];
          hit_d   = rd_entry;
          state_d = S_WRITE;
        end else if (last_slot) begin
          state_d = S_INS;
        end else begin
          ptr_d   = ptr_q + IdxW'(1);
          state_d = S_READ;
        end
      end
      S_WRITE: begin
        // read-modify-write of the matched slot
        ram_we         = 1'b1;
        ram_waddr      = ptr_q;
        ram_wdata      = hit_q;
        ram_wdata.count = sum_q;
        res_acc_d      = 1'b1;
        res_mrg_d      = 1'b1;
        res_idx_d      = ptr_q;
        state_d        = S_DONE;
      end
      S_INS: begin
        if (fill_q != FillFull) begin
          ram_we             = 1'b1;
          ram_waddr          = fill_q[IdxW-1:0];
          ram_wdata.item     = id_q;
          ram_wdata.position = pos_q;
          ram_wdata.count    = rtwm_pkg::CountW'(amount_q);
          res_acc_d          = 1'b1;
          res_idx_d          = fill_q[IdxW-1:0];
          fill_d             = fill_q + FillW'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    res_acc_q <= res_acc_d;
    res_mrg_q <= res_mrg_d;
    res_idx_q <= res_idx_d;
    sum_q     <= sum_d;
    hit_q     <= hit_d;
    if (in_fire) begin
      kind_q   <= kind_i;
      id_q     <= item_id_i;
      amount_q <= amount_i;
      pos_q    <= position_i;
    end
    if (out_load) begin
      out_acc_q <= res_acc_q;
      out_mrg_q <= res_mrg_q;
      out_idx_q <= rtwm_pkg::SlotIdxW'(res_idx_q);
      // fill count is final by now, also after a clear
      out_any_q <= (fill_q != '0) && (kind_q == rtwm_pkg::KindPush);
    end
  end

  rtwm_ram #(
    .Width (EntW),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign merged_o       = out_mrg_q;
  assign slot_index_o   = out_idx_q;
  assign any_reserved_o = out_any_q;

endmodule

FILE: hdl/rtwm_checker.sv
// ----------------------------------------------------------------------------
// rtwm_checker
// port-level checks of the reservation table results
// ----------------------------------------------------------------------------
module rtwm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          accepted_o,
  input logic                          merged_o,
  input logic [rtwm_pkg::SlotIdxW-1:0] slot_index_o
  , input logic                        any_reserved_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(accepted_o) && $stable(merged_o) && $stable(slot_index_o) &&
      $stable(any_reserved_o))
    else $error("result changed while stalled");

  a_merge_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merged_o |-> accepted_o)
    else $error("merge reported on a refused transaction");

  a_refused_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> (slot_index_o == '0))
    else $error("refused transaction with nonzero slot index");

  a_acc_implies_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> any_reserved_o)
    else $error("accepted transaction but table reported empty");

endmodule

bind reserve_table_wildcard_merge rtwm_checker u_rtwm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .merged_o       (merged_o),
  .slot_index_o   (slot_index_o),
  .any_reserved_o (any_reserved_o)
);

FILE: tb/reserve_table_wildcard_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reserve_table_wildcard_merge_tb
// self-checking bench for the reservation table: a queue-fed driver sends
// push and clear transactions in random bursts, a shadow table predicts
// every result, and a monitor behind a stalling receiver compares each
// result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module reserve_table_wildcard_merge_tb;

  localparam int unsigned ENTRIES     = 8;
  localparam int unsigned RandomItems = 1550;
  // margin after the last result, so that any stray late result is still caught
  localparam int unsigned SettleCycles = 4 * ENTRIES + 16;

  // one pending input transaction, or a marker that holds the sender back
  // until every predicted result has come out
  typedef struct {
    logic                             wait_idle;
    logic                             kind;
    logic [rtwm_pkg::IdW-1:0]         item_id;
    logic [rtwm_pkg::AmountW-1:0]     amount;
    logic signed [rtwm_pkg::PosW-1:0] position;
  } request_t;

  typedef struct packed {
    logic                          accepted;
    logic                          merged;
    logic [rtwm_pkg::SlotIdxW-1:0] slot_index;
    logic                          any_reserved;
  } outcome_t;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_ready_o;
  logic                             kind_i       = rtwm_pkg::KindPush;
  logic [rtwm_pkg::IdW-1:0]         item_id_i    = '0;
  logic [rtwm_pkg::AmountW-1:0]     amount_i     = '0;
  logic signed [rtwm_pkg::PosW-1:0] position_i   = '0;
  logic                             out_valid_o;
  logic                             out_ready_i  = 1'b0;
  logic                             accepted_o;
  logic                             merged_o;
  logic [rtwm_pkg::SlotIdxW-1:0]    slot_index_o;
  logic                             any_reserved_o;

  // shadow copy of the table
  logic [rtwm_pkg::IdW-1:0]    shadow_item  [ENTRIES];
  logic [rtwm_pkg::PosW-1:0]   shadow_pos   [ENTRIES];
  logic [rtwm_pkg::CountW-1:0] shadow_count [ENTRIES];

  request_t pending_q[$];
  outcome_t outcome_q[$];
  request_t live_req;

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned rx_mode        = 0;
  int unsigned rx_phase       = 0;

  always #6 clk_i = ~clk_i;

  reserve_table_wildcard_merge #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .item_id_i     (item_id_i),
    .amount_i      (amount_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .merged_o      (merged_o),
    .slot_index_o  (slot_index_o),
    .any_reserved_o(any_reserved_o)
  );

  // --------------------------------------------------------------------------
  // shadow table: applies one accepted transaction and returns its outcome
  // --------------------------------------------------------------------------
  function automatic outcome_t reserve_predict(request_t r);
    outcome_t                  o;
    int                        hit;
    logic [rtwm_pkg::CountW:0] total;
    o   = '0;
    hit = -1;
    if (r.kind == rtwm_pkg::KindClear) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_item[i]  = '0;
        shadow_pos[i]   = '0;
        shadow_count[i] = '0;
      end
    end else if (r.item_id != '0) begin
      // lowest slot with the same id and either the same position or a
      // wildcard on the incoming transaction
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && shadow_item[i] == r.item_id &&
            (r.position == rtwm_pkg::PosAny || shadow_pos[i] == r.position)) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        total = {1'b0, shadow_count[hit]} + (rtwm_pkg::CountW + 1)'(r.amount);
        shadow_count[hit] = (total > {1'b0, rtwm_pkg::CountMax}) ? rtwm_pkg::CountMax
                                                                 : total[rtwm_pkg::CountW-1:0];
        o.accepted   = 1'b1;
        o.merged     = 1'b1;
        o.slot_index = hit[rtwm_pkg::SlotIdxW-1:0];
      end else begin
        // no match: lowest empty slot takes it, or the push is refused
        for (int i = 0; i < ENTRIES; i++) begin
          if (!o.accepted && shadow_item[i] == '0) begin
            shadow_item[i]  = r.item_id;
            shadow_pos[i]   = r.position;
            shadow_count[i] = rtwm_pkg::CountW'(r.amount);
            o.accepted      = 1'b1;
            o.slot_index    = i[rtwm_pkg::SlotIdxW-1:0];
          end
        end
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_item[i] != '0) o.any_reserved = 1'b1;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 40) begin
      $display("[%0t] result %0d: %s got %0d expected %0d",
               $time, results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void queue_request(logic kind, logic [rtwm_pkg::IdW-1:0] id,
                                        logic [rtwm_pkg::AmountW-1:0] amt,
                                        logic signed [rtwm_pkg::PosW-1:0] pos);
    request_t r;
    r.wait_idle = 1'b0;
    r.kind      = kind;
    r.item_id   = id;
    r.amount    = amt;
    r.position  = pos;
    pending_q.push_back(r);
  endfunction

  function automatic void queue_idle_wait();
    request_t r;
    r = '{wait_idle: 1'b1, kind: rtwm_pkg::KindPush, item_id: '0, amount: '0,
          position: '0};
    pending_q.push_back(r);
  endfunction

  // position drawn mostly from a small pool so that matches happen, with the
  // wildcard, the signed extremes, minus two and fully random patterns mixed in
  function automatic logic signed [rtwm_pkg::PosW-1:0] pick_position(bit wide);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (wide && sel > 6) return rtwm_pkg::PosW'($urandom());
    case (sel)
      0, 1:    return rtwm_pkg::PosAny;
      2:       return 9'sh100;
      3:       return 9'sh1FE;
      4:       return 9'sh0FF;
      default: return rtwm_pkg::PosW'($urandom_range(0, 2));
    endcase
  endfunction

  // segment styles:
  //   0 tight id pool and large amounts, drives counts into saturation
  //   1 moderate pool, fills the table and hits the full case, some clears
  //   2 noise: any id including zero, any position, frequent clears
  function automatic request_t make_request(int unsigned style);
    request_t r;
    r.wait_idle = 1'b0;
    r.kind      = rtwm_pkg::KindPush;
    r.amount    = rtwm_pkg::AmountW'($urandom());
    case (style)
      0: begin
        if ($urandom_range(0, 199) == 0) r.kind = rtwm_pkg::KindClear;
        r.item_id = rtwm_pkg::IdW'($urandom_range(1, 3));
        if ($urandom_range(0, 2) != 0) r.amount = '1;
        r.position = pick_position(1'b0);
      end
      1: begin
        if ($urandom_range(0, 24) == 0) r.kind = rtwm_pkg::KindClear;
        r.item_id = rtwm_pkg::IdW'($urandom_range(1, 14));
        r.position = pick_position(1'b0);
      end
      default: begin
        if ($urandom_range(0, 9) == 0) r.kind = rtwm_pkg::KindClear;
        r.item_id = ($urandom_range(0, 7) == 0) ? '0 : rtwm_pkg::IdW'($urandom());
        if ($urandom_range(0, 3) == 0) r.item_id = rtwm_pkg::IdW'($urandom_range(1, 4));
        r.position = pick_position(1'b1);
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driver: bursts of transactions separated by random gaps; a pending
  // transaction is held with its payload until the handshake takes it
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // predict at the moment of acceptance, so the expectation order
      // matches the order the block sees
      if (in_valid_i && in_ready_o) outcome_q.push_back(reserve_predict(live_req));

      if (in_valid_i && !in_ready_o) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_q[0].wait_idle) begin
        // sender pause until the block has handed back everything
        in_valid_i <= 1'b0;
        if (outcome_q.size() == 0) void'(pending_q.pop_front());
      end else begin
        nxt = pending_q.pop_front();
        live_req   = nxt;
        in_valid_i <= 1'b1;
        kind_i     <= nxt.kind;
        item_id_i  <= nxt.item_id;
        amount_i   <= nxt.amount;
        position_i <= nxt.position;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor and receiver: checks each result, then picks the next ready value
  // from a stall pattern that is redrawn at random by a phase counter of elapsed cycles
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_phase = 0;
      rx_mode  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result, accepted", accepted_o, 0);
        end else begin
          want = outcome_q.pop_front();
          if (accepted_o !== want.accepted)
            report_mismatch("accepted", accepted_o, want.accepted);
          if (merged_o !== want.merged)
            report_mismatch("merged", merged_o, want.merged);
          if (slot_index_o !== want.slot_index)
            report_mismatch("slot_index", slot_index_o, want.slot_index);
          if (any_reserved_o !== want.any_reserved)
            report_mismatch("any_reserved", any_reserved_o, want.any_reserved);
        end
      end

      rx_phase++;
      if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (rx_phase % 4 == 0);
        default: out_ready_i <= ((rx_phase / 8) % 4 != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned made;
    int unsigned style;
    int unsigned seg_len;
    request_t    r;

    for (int i = 0; i < ENTRIES; i++) begin
      shadow_item[i]  = '0;
      shadow_pos[i]   = '0;
      shadow_count[i] = '0;
    end

    // directed: id zero on an empty table, insert, exact and wildcard merge
    queue_request(rtwm_pkg::KindPush, 16'd0, 16'd9, 9'sd3);
    queue_request(rtwm_pkg::KindPush, 16'd1, 16'd5, 9'sd3);
    queue_request(rtwm_pkg::KindPush, 16'd1, 16'd7, 9'sd3);
    queue_request(rtwm_pkg::KindPush, 16'd1, 16'd1, rtwm_pkg::PosAny);
    queue_request(rtwm_pkg::KindPush, 16'd1, 16'd2, 9'sd4);
    // stored wildcard only matches another wildcard
    queue_request(rtwm_pkg::KindPush, 16'd2, 16'd3, rtwm_pkg::PosAny);
    queue_request(rtwm_pkg::KindPush, 16'd2, 16'd4, 9'sd5);
    queue_request(rtwm_pkg::KindPush, 16'd2, 16'd6, rtwm_pkg::PosAny);
    // field extremes and negative positions that are not the wildcard
    queue_request(rtwm_pkg::KindPush, 16'hFFFF, 16'hFFFF, 9'sh100);
    queue_request(rtwm_pkg::KindPush, 16'hFFFF, 16'h0000, 9'sh1FE);
    queue_request(rtwm_pkg::KindPush, 16'hFFFF, 16'h0000, 9'sh0FF);
    queue_request(rtwm_pkg::KindPush, 16'd3, 16'hAAAA, 9'sd0);
    // table full: no match and no empty slot, then id zero on a busy table
    queue_request(rtwm_pkg::KindPush, 16'd4, 16'h5555, 9'sd0);
    queue_request(rtwm_pkg::KindPush, 16'd0, 16'h1234, rtwm_pkg::PosAny);
    queue_request(rtwm_pkg::KindPush, 16'hFFFF, 16'hFFFF, 9'sh100);
    queue_request(rtwm_pkg::KindClear, 16'hFFFF, 16'hFFFF, rtwm_pkg::PosAny);
    queue_request(rtwm_pkg::KindPush, 16'h8000, 16'h8000, 9'sd0);
    queue_request(rtwm_pkg::KindClear, 16'd0, 16'd0, 9'sd0);
    queue_idle_wait();

    // random: segments of one style, sometimes ending in a sender pause
    made = 0;
    while (made < RandomItems) begin
      style   = $urandom_range(0, 4);
      style   = (style > 2) ? 1 : style;
      seg_len = $urandom_range(20, 80);
      for (int k = 0; k < seg_len && made < RandomItems; k++) begin
        r = make_request(style);
        pending_q.push_back(r);
        made++;
      end
      if ($urandom_range(0, 3) == 0) queue_idle_wait();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last transaction to go in and its result to come out
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || outcome_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS reserve_table_wildcard_merge");
    end else begin
      $display("FAIL reserve_table_wildcard_merge");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL reserve_table_wildcard_merge");
    $finish;
  end

endmodule
